@@ hdl/tcce_pkg.sv @@
package tcce_pkg;

	localparam int COLS   = 80;
	localparam int ROWS   = 25;
	localparam int CELLS  = COLS * ROWS;
	localparam int COL_W  = $clog2(COLS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int LN_W   = ROW_W + 1;
	localparam int ADDR_W = $clog2(CELLS);

	// port widths fixed by the interface
	localparam int OUT_COL_W = 7;
	localparam int OUT_ROW_W = 5;
	localparam int OUT_OFF_W = 11;

	localparam logic [2:0] OP_PUTC   = 3'd0;
	localparam logic [2:0] OP_SETCUR = 3'd1;
	localparam logic [2:0] OP_CLEAR  = 3'd2;
	localparam logic [2:0] OP_SCRUP  = 3'd3;
	localparam logic [2:0] OP_SCRDN  = 3'd4;
	localparam logic [2:0] OP_READ   = 3'd5;

	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_BLANK = 8'h20;

	localparam logic [7:0] RESET_ATTR = 8'h0F;

	typedef struct packed {
		logic accept;
		logic put_wr;
		logic sw_rd;
		logic sw_blank;
		logic sw_copy;
		logic rd_issue;
		logic rd_cap;
		logic res_load;
	} tcce_cmd_t;

	typedef struct packed {
		logic is_putc;
		logic is_read;
		logic start_sweep;
		logic scroll_q;
		logic src_valid;
		logic sw_last;
	} tcce_stat_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		logic [ADDR_W+COL_W-1:0] prod;
		prod = (ADDR_W+COL_W)'(r) * (ADDR_W+COL_W)'(COLS) + (ADDR_W+COL_W)'(c);
		return prod[ADDR_W-1:0];
	endfunction

endpackage

@@ hdl/tcce_ram.sv @@
module tcce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ hdl/tcce_ctrl.sv @@
module tcce_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  tcce_pkg::tcce_stat_t stat,
	output tcce_pkg::tcce_cmd_t  cmd
);
	import tcce_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_PUT, S_SWEEP, S_SW_WR, S_RD1, S_RD2, S_LOAD, S_RESP
	} state_t;

	state_t state_q;
	logic   init_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_RESP);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:  cmd.accept   = in_valid;
			S_PUT:   cmd.put_wr   = 1'b1;
			S_SWEEP: begin
				cmd.sw_rd    = stat.src_valid;
				cmd.sw_blank = !stat.src_valid;
			end
			S_SW_WR: cmd.sw_copy  = 1'b1;
			S_RD1:   cmd.rd_issue = 1'b1;
			S_RD2:   cmd.rd_cap   = 1'b1;
			S_LOAD:  cmd.res_load = 1'b1;
			S_RESP:  cmd = '0;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			init_q  <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						priority if (stat.is_putc) state_q <= S_PUT;
						else if (stat.start_sweep) state_q <= S_SWEEP;
						else if (stat.is_read) state_q <= S_RD1;
						else state_q <= S_LOAD;
					end
				end
				S_PUT: state_q <= stat.scroll_q ? S_SWEEP : S_LOAD;
				S_SWEEP: begin
					if (stat.src_valid) begin
						state_q <= S_SW_WR;
					end else if (stat.sw_last) begin
						state_q <= init_q ? S_IDLE : S_LOAD;
						init_q  <= 1'b0;
					end
				end
				S_SW_WR: begin
					if (stat.sw_last) begin
						state_q <= S_LOAD;
					end else begin
						state_q <= S_SWEEP;
					end
				end
				S_RD1:  state_q <= S_RD2;
				S_RD2:  state_q <= S_LOAD;
				S_LOAD: state_q <= S_RESP;
				S_RESP: begin
					if (!out_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ hdl/tcce_dp.sv @@
module tcce_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tcce_pkg::tcce_cmd_t            cmd,
	output tcce_pkg::tcce_stat_t           stat,
	input  logic                           cfg_valid,
	input  logic [7:0]                     cfg_data,
	input  logic [2:0]                     op,
	input  logic [7:0]                     char_code,
	input  logic [7:0]                     col,
	input  logic [7:0]                     row,
	input  logic [7:0]                     line_count,
	input  logic [7:0]                     fill_attr,
	input  logic [7:0]                     win_top,
	input  logic [7:0]                     win_left,
	input  logic [7:0]                     win_bottom,
	input  logic [7:0]                     win_right,
	output logic [tcce_pkg::OUT_COL_W-1:0] cursor_col,
	output logic [tcce_pkg::OUT_ROW_W-1:0] cursor_row,
	output logic [tcce_pkg::OUT_OFF_W-1:0] cursor_offset,
	output logic [15:0]                    cell_data
);
	import tcce_pkg::*;

	logic [7:0]       attr_q;
	logic [COL_W-1:0] cur_col_q;
	logic [ROW_W-1:0] cur_row_q;

	logic [ROW_W-1:0] sw_r_q, top_q, bot_q;
	logic [COL_W-1:0] sw_c_q, left_q, right_q;
	logic [LN_W-1:0]  lines_q;
	logic             down_q;
	logic [7:0]       fill_q;

	logic              put_we_q, scroll_q;
	logic [ADDR_W-1:0] put_addr_q;
	logic [15:0]       put_data_q;
	logic              rd_ok_q;
	logic [ADDR_W-1:0] rd_addr_q;
	logic [15:0]       cell_q;

	logic [15:0]       ram_rdata;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [15:0]       ram_wdata;

	// put char decode
	logic [COL_W:0]   pc_col;
	logic [ROW_W:0]   pc_row;
	logic             pc_we, pc_scroll;
	logic [COL_W-1:0] pc_wcol;
	logic [7:0]       pc_wchar;

	always_comb begin
		pc_col   = {1'b0, cur_col_q};
		pc_row   = {1'b0, cur_row_q};
		pc_we    = 1'b0;
		pc_wcol  = cur_col_q;
		pc_wchar = char_code;
		priority if (char_code == CH_NL) begin
			pc_col = '0;
			pc_row = pc_row + 1'b1;
		end else if (char_code == CH_CR) begin
			pc_col = '0;
		end else if (char_code == CH_TAB) begin
			pc_col = ({1'b0, cur_col_q} + (COL_W+1)'(8)) & ~((COL_W+1)'(7));
		end else if (char_code == CH_BS) begin
			if (cur_col_q != '0) begin
				pc_col   = {1'b0, cur_col_q} - 1'b1;
				pc_we    = 1'b1;
				pc_wcol  = cur_col_q - 1'b1;
				pc_wchar = CH_BLANK;
			end
		end else begin
			pc_we  = 1'b1;
			pc_col = {1'b0, cur_col_q} + 1'b1;
		end
		if (pc_col >= (COL_W+1)'(COLS)) begin
			pc_col = '0;
			pc_row = pc_row + 1'b1;
		end
		pc_scroll = (pc_row >= (ROW_W+1)'(ROWS));
		if (pc_scroll) pc_row = (ROW_W+1)'(ROWS - 1);
	end

	// window clamp for scroll ops
	logic [7:0] wb, wr, wh, wl;
	logic       win_ok;

	always_comb begin
		wb     = (win_bottom > 8'(ROWS - 1)) ? 8'(ROWS - 1) : win_bottom;
		wr     = (win_right > 8'(COLS - 1)) ? 8'(COLS - 1) : win_right;
		win_ok = (win_top <= wb) && (win_left <= wr);
		wh     = wb - win_top + 8'd1;
		wl     = (line_count == 8'd0 || line_count >= wh) ? wh : line_count;
	end

	logic is_scr;
	assign is_scr = (op == OP_SCRUP) || (op == OP_SCRDN);

	// sweep
	logic [LN_W-1:0]  r_ext;
	logic [ROW_W-1:0] src_row, end_row;
	logic             src_valid, sw_last, sw_step;

	always_comb begin
		r_ext   = LN_W'(sw_r_q);
		end_row = down_q ? top_q : bot_q;
		if (down_q) begin
			src_valid = r_ext >= (LN_W'(top_q) + lines_q);
			src_row   = ROW_W'(r_ext - lines_q);
		end else begin
			src_valid = (r_ext + lines_q) <= LN_W'(bot_q);
			src_row   = ROW_W'(r_ext + lines_q);
		end
		sw_last = (sw_c_q == right_q) && (sw_r_q == end_row);
		sw_step = cmd.sw_blank || cmd.sw_copy;
	end

	assign stat.is_putc     = (op == OP_PUTC);
	assign stat.is_read     = (op == OP_READ);
	assign stat.start_sweep = (op == OP_CLEAR) || (is_scr && win_ok);
	assign stat.scroll_q    = scroll_q;
	assign stat.src_valid   = src_valid;
	assign stat.sw_last     = sw_last;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cell_addr(sw_r_q, sw_c_q);
		ram_wdata = {fill_q, CH_BLANK};
		priority if (cmd.put_wr) begin
			ram_we    = put_we_q;
			ram_waddr = put_addr_q;
			ram_wdata = put_data_q;
		end else if (cmd.sw_copy) begin
			ram_we    = 1'b1;
			ram_wdata = ram_rdata;
		end else if (cmd.sw_blank) begin
			ram_we = 1'b1;
		end
		ram_raddr = cmd.rd_issue ? rd_addr_q : cell_addr(src_row, sw_c_q);
	end

	tcce_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q    <= RESET_ATTR;
			cur_col_q <= '0;
			cur_row_q <= '0;
			sw_r_q    <= '0;
			sw_c_q    <= '0;
			top_q     <= '0;
			left_q    <= '0;
			bot_q     <= ROW_W'(ROWS - 1);
			right_q   <= COL_W'(COLS - 1);
			lines_q   <= LN_W'(ROWS);
			down_q    <= 1'b0;
			fill_q    <= RESET_ATTR;
			put_we_q  <= 1'b0;
			scroll_q  <= 1'b0;
			rd_ok_q   <= 1'b0;
		end else begin
			if (cfg_valid) attr_q <= cfg_data;
			if (cmd.accept) begin
				// full screen window by default: used by clear and line-feed scroll
				top_q    <= '0;
				left_q   <= '0;
				bot_q    <= ROW_W'(ROWS - 1);
				right_q  <= COL_W'(COLS - 1);
				sw_r_q   <= '0;
				sw_c_q   <= '0;
				lines_q  <= LN_W'(1);
				down_q   <= 1'b0;
				fill_q   <= attr_q;
				put_we_q <= 1'b0;
				scroll_q <= 1'b0;
				rd_ok_q  <= (row < 8'(ROWS)) && (col < 8'(COLS));
				unique case (op)
					OP_PUTC: begin
						cur_col_q <= pc_col[COL_W-1:0];
						cur_row_q <= pc_row[ROW_W-1:0];
						put_we_q  <= pc_we;
						scroll_q  <= pc_scroll;
					end
					OP_SETCUR: begin
						cur_col_q <= (col >= 8'(COLS)) ? COL_W'(COLS - 1) : col[COL_W-1:0];
						cur_row_q <= (row >= 8'(ROWS)) ? ROW_W'(ROWS - 1) : row[ROW_W-1:0];
					end
					OP_CLEAR: begin
						lines_q   <= LN_W'(ROWS);
						cur_col_q <= '0;
						cur_row_q <= '0;
					end
					OP_SCRUP, OP_SCRDN: begin
						top_q   <= win_top[ROW_W-1:0];
						left_q  <= win_left[COL_W-1:0];
						bot_q   <= wb[ROW_W-1:0];
						right_q <= wr[COL_W-1:0];
						lines_q <= wl[LN_W-1:0];
						down_q  <= (op == OP_SCRDN);
						fill_q  <= fill_attr;
						sw_r_q  <= (op == OP_SCRDN) ? wb[ROW_W-1:0] : win_top[ROW_W-1:0];
						sw_c_q  <= win_left[COL_W-1:0];
					end
					default: ;
				endcase
			end else if (sw_step) begin
				if (sw_c_q == right_q) begin
					sw_c_q <= left_q;
					sw_r_q <= down_q ? sw_r_q - 1'b1 : sw_r_q + 1'b1;
				end else begin
					sw_c_q <= sw_c_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			put_addr_q <= cell_addr(cur_row_q, pc_wcol);
			put_data_q <= {attr_q, pc_wchar};
			rd_addr_q  <= cell_addr(row[ROW_W-1:0], col[COL_W-1:0]);
			cell_q     <= '0;
		end else if (cmd.rd_cap && rd_ok_q) begin
			cell_q <= ram_rdata;
		end
		if (cmd.res_load) begin
			cursor_col    <= OUT_COL_W'(cur_col_q);
			cursor_row    <= OUT_ROW_W'(cur_row_q);
			cursor_offset <= OUT_OFF_W'(cell_addr(cur_row_q, cur_col_q));
			cell_data     <= cell_q;
		end
	end
endmodule

@@ hdl/text_console_cell_engine.sv @@
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  op .. win_right
// out       output     out_valid/out_stall  cursor_col, cursor_row, cursor_offset, cell_data
// cfg       input      cfg_valid/cfg_ready  cfg_data (text attribute)
//
// one transaction at a time; set cursor and no-op codes load the result directly, read
// cell reads the store first, put char has a write step plus a full-screen scroll when
// the cursor leaves the last row; a window scroll walks the window once through the cell
// store (one read, one write port): a moved cell is read then written, a blank only written
// after reset a clearing pass fills the store before in_stall drops
// a result is held until out_stall is low; config is always taken
module text_console_cell_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     op,
	input  logic [7:0]                     char_code,
	input  logic [7:0]                     col,
	input  logic [7:0]                     row,
	input  logic [7:0]                     line_count,
	input  logic [7:0]                     fill_attr,
	input  logic [7:0]                     win_top,
	input  logic [7:0]                     win_left,
	input  logic [7:0]                     win_bottom,
	input  logic [7:0]                     win_right,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [tcce_pkg::OUT_COL_W-1:0] cursor_col,
	output logic [tcce_pkg::OUT_ROW_W-1:0] cursor_row,
	output logic [tcce_pkg::OUT_OFF_W-1:0] cursor_offset,
	output logic [15:0]                    cell_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [7:0]                     cfg_data
);
	import tcce_pkg::*;

	tcce_cmd_t  cmd;
	tcce_stat_t stat;

	assign cfg_ready = 1'b1;

	tcce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	tcce_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.op            (op),
		.char_code     (char_code),
		.col           (col),
		.row           (row),
		.line_count    (line_count),
		.fill_attr     (fill_attr),
		.win_top       (win_top),
		.win_left      (win_left),
		.win_bottom    (win_bottom),
		.win_right     (win_right),
		.cursor_col    (cursor_col),
		.cursor_row    (cursor_row),
		.cursor_offset (cursor_offset),
		.cell_data     (cell_data)
	);
endmodule

@@ tb/text_console_cell_engine_test.sv @@
module text_console_cell_engine_test;
	import tcce_pkg::*;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] char_code;
		logic [7:0] col;
		logic [7:0] row;
		logic [7:0] line_count;
		logic [7:0] fill_attr;
		logic [7:0] win_top;
		logic [7:0] win_left;
		logic [7:0] win_bottom;
		logic [7:0] win_right;
	} console_cmd_t;

	typedef struct packed {
		logic [6:0]  cur_col;
		logic [4:0]  cur_row;
		logic [10:0] offset;
		logic [15:0] data;
	} console_view_t;

	localparam int CYCLE_LIMIT = 4_000_000;
	localparam logic [2:0] OP_NONE = 3'd6;
	localparam logic [2:0] OP_SPARE = 3'd7;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [2:0] op;
	logic [7:0] char_code, col, row, line_count, fill_attr;
	logic [7:0] win_top, win_left, win_bottom, win_right;
	logic [6:0] cursor_col;
	logic [4:0] cursor_row;
	logic [10:0] cursor_offset;
	logic [15:0] cell_data;
	logic cfg_valid, cfg_ready;
	logic [7:0] cfg_data;

	text_console_cell_engine uut (.*);

	// shadow screen and cursor
	logic [15:0] screen [CELLS];
	int unsigned cur_x, cur_y;
	logic [7:0] attr_shadow;

	console_cmd_t pending_cmds[$];
	console_view_t expected_views[$];
	int mismatches;
	int cycles;
	int unsigned gap_left;
	int unsigned stall_left;
	logic feeding_done;

	function automatic logic [15:0] cell_of(logic [7:0] ch, logic [7:0] a);
		return {a, ch};
	endfunction

	function automatic logic [15:0] peek(int unsigned r, int unsigned c);
		if (r < ROWS && c < COLS)
			return screen[r * COLS + c];
		return 16'h0;
	endfunction

	function automatic void poke(int unsigned r, int unsigned c, logic [15:0] v);
		if (r < ROWS && c < COLS)
			screen[r * COLS + c] = v;
	endfunction

	function automatic void roll_screen();
		for (int i = 0; i < COLS * (ROWS - 1); i++)
			screen[i] = screen[i + COLS];
		for (int i = COLS * (ROWS - 1); i < CELLS; i++)
			screen[i] = cell_of(CH_BLANK, attr_shadow);
		cur_y = ROWS - 1;
	endfunction

	function automatic void type_char(logic [7:0] ch);
		if (ch == CH_NL) begin
			cur_x = 0;
			cur_y++;
		end else if (ch == CH_CR) begin
			cur_x = 0;
		end else if (ch == CH_TAB) begin
			cur_x = (cur_x + 8) & ~32'd7;
		end else if (ch == CH_BS) begin
			if (cur_x > 0) begin
				cur_x--;
				poke(cur_y, cur_x, cell_of(CH_BLANK, attr_shadow));
			end
		end else begin
			poke(cur_y, cur_x, cell_of(ch, attr_shadow));
			cur_x++;
		end
		if (cur_x >= COLS) begin
			cur_x = 0;
			cur_y++;
		end
		if (cur_y >= ROWS)
			roll_screen();
	endfunction

	function automatic void shift_window(bit down, console_cmd_t c);
		int unsigned top, left, bot, rgt, n, h;
		logic [15:0] blank;
		top = c.win_top;
		left = c.win_left;
		bot = c.win_bottom > ROWS - 1 ? ROWS - 1 : c.win_bottom;
		rgt = c.win_right > COLS - 1 ? COLS - 1 : c.win_right;
		blank = cell_of(CH_BLANK, c.fill_attr);
		if (top > bot || left > rgt)
			return;
		h = bot - top + 1;
		n = c.line_count;
		if (n == 0 || n >= h)
			n = h;
		if (!down) begin
			for (int r = top; r + n <= bot; r++)
				for (int k = left; k <= rgt; k++)
					poke(r, k, peek(r + n, k));
			for (int r = bot + 1 - n; r <= bot; r++)
				for (int k = left; k <= rgt; k++)
					poke(r, k, blank);
		end else begin
			for (int r = bot; r >= int'(top + n); r--)
				for (int k = left; k <= rgt; k++)
					poke(r, k, peek(r - n, k));
			for (int r = top; r < top + n; r++)
				for (int k = left; k <= rgt; k++)
					poke(r, k, blank);
		end
	endfunction

	function automatic console_view_t apply_cmd(console_cmd_t c);
		console_view_t v;
		logic [15:0] d;
		d = 16'h0;
		case (c.op)
			OP_PUTC: type_char(c.char_code);
			OP_SETCUR: begin
				cur_x = c.col >= COLS ? COLS - 1 : c.col;
				cur_y = c.row >= ROWS ? ROWS - 1 : c.row;
			end
			OP_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					screen[i] = cell_of(CH_BLANK, attr_shadow);
				cur_x = 0;
				cur_y = 0;
			end
			OP_SCRUP: shift_window(1'b0, c);
			OP_SCRDN: shift_window(1'b1, c);
			OP_READ: d = peek(c.row, c.col);
			default: ;
		endcase
		v.cur_col = 7'(cur_x);
		v.cur_row = 5'(cur_y);
		v.offset = 11'(cur_y * COLS + cur_x);
		v.data = d;
		return v;
	endfunction

	function automatic console_cmd_t rand_cmd();
		console_cmd_t c;
		c = console_cmd_t'({$urandom, $urandom, $urandom});
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				c.op = OP_PUTC;
				if ($urandom_range(0, 3) == 0)
					c.char_code = $urandom_range(0, 1) ? CH_NL : ($urandom_range(0, 1) ? CH_CR :
						($urandom_range(0, 1) ? CH_TAB : CH_BS));
			end
			4: c.op = OP_SETCUR;
			5: c.op = $urandom_range(0, 5) == 0 ? OP_CLEAR :
				($urandom_range(0, 1) ? OP_NONE : OP_SPARE);
			6, 7: begin
				c.op = $urandom_range(0, 1) ? OP_SCRUP : OP_SCRDN;
				// mostly small windows so the run stays short
				if ($urandom_range(0, 7) != 0) begin
					c.win_top = 8'($urandom_range(0, 26));
					c.win_bottom = c.win_top + 8'($urandom_range(0, 4));
					c.win_left = 8'($urandom_range(0, 82));
					c.win_right = c.win_left + 8'($urandom_range(0, 12));
					c.line_count = 8'($urandom_range(0, 6));
				end
			end
			default: begin
				c.op = OP_READ;
				if ($urandom_range(0, 4) != 0) begin
					c.col = 8'($urandom_range(0, 81));
					c.row = 8'($urandom_range(0, 26));
				end
			end
		endcase
		return c;
	endfunction

	function automatic console_cmd_t mk(logic [2:0] o, logic [7:0] ch, logic [7:0] x,
			logic [7:0] y);
		console_cmd_t c;
		c = '0;
		c.op = o;
		c.char_code = ch;
		c.col = x;
		c.row = y;
		return c;
	endfunction

	function automatic console_cmd_t mkwin(logic [2:0] o, logic [7:0] n, logic [7:0] f,
			logic [7:0] t, logic [7:0] l, logic [7:0] b, logic [7:0] r);
		console_cmd_t c;
		c = '0;
		c.op = o;
		c.line_count = n;
		c.fill_attr = f;
		c.win_top = t;
		c.win_left = l;
		c.win_bottom = b;
		c.win_right = r;
		return c;
	endfunction

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || in_valid || expected_views.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_attr(logic [7:0] a);
		cfg_data <= a;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		attr_shadow = a;
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		feeding_done = 1'b0;
		attr_shadow = RESET_ATTR;
		cur_x = 0;
		cur_y = 0;
		for (int i = 0; i < CELLS; i++)
			screen[i] = 16'h0F20;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: controls, wrap, tab, backspace at edge, clamps, windows, reads
		pending_cmds.push_back(mk(OP_READ, 8'h00, 8'd0, 8'd0));
		pending_cmds.push_back(mk(OP_PUTC, 8'h41, 8'd0, 8'd0));
		pending_cmds.push_back(mk(OP_PUTC, 8'hFF, 8'd0, 8'd0));
		pending_cmds.push_back(mk(OP_PUTC, 8'h00, 8'd0, 8'd0));
		pending_cmds.push_back(mk(OP_PUTC, CH_BS, 8'd0, 8'd0));
		pending_cmds.push_back(mk(OP_PUTC, CH_CR, 8'd0, 8'd0));
		pending_cmds.push_back(mk(OP_PUTC, CH_BS, 8'd0, 8'd0));
		pending_cmds.push_back(mk(OP_PUTC, CH_TAB, 8'd0, 8'd0));
		pending_cmds.push_back(mk(OP_SETCUR, 8'h00, 8'd255, 8'd255));
		pending_cmds.push_back(mk(OP_PUTC, 8'h5A, 8'd0, 8'd0));
		pending_cmds.push_back(mk(OP_SETCUR, 8'h00, 8'd75, 8'd3));
		pending_cmds.push_back(mk(OP_PUTC, CH_TAB, 8'd0, 8'd0));
		pending_cmds.push_back(mk(OP_SETCUR, 8'h00, 8'd0, 8'd24));
		pending_cmds.push_back(mk(OP_PUTC, CH_NL, 8'd0, 8'd0));
		pending_cmds.push_back(mk(OP_READ, 8'h00, 8'd0, 8'd23));
		pending_cmds.push_back(mk(OP_READ, 8'h00, 8'd80, 8'd0));
		pending_cmds.push_back(mk(OP_READ, 8'h00, 8'd0, 8'd255));
		pending_cmds.push_back(mkwin(OP_SCRUP, 8'd1, 8'hA5, 8'd0, 8'd0, 8'd255, 8'd255));
		pending_cmds.push_back(mkwin(OP_SCRDN, 8'd2, 8'h5A, 8'd2, 8'd3, 8'd6, 8'd10));
		pending_cmds.push_back(mkwin(OP_SCRUP, 8'd0, 8'hFF, 8'd4, 8'd4, 8'd5, 8'd5));
		pending_cmds.push_back(mkwin(OP_SCRDN, 8'd255, 8'h00, 8'd20, 8'd70, 8'd22, 8'd79));
		pending_cmds.push_back(mkwin(OP_SCRUP, 8'd1, 8'h11, 8'd9, 8'd0, 8'd5, 8'd5));
		pending_cmds.push_back(mkwin(OP_SCRDN, 8'd1, 8'h11, 8'd0, 8'd255, 8'd3, 8'd5));
		pending_cmds.push_back(mk(OP_NONE, 8'h00, 8'd0, 8'd0));
		pending_cmds.push_back(mk(OP_SPARE, 8'h00, 8'd0, 8'd0));
		pending_cmds.push_back(mk(OP_CLEAR, 8'h00, 8'd0, 8'd0));
		wait_drained();

		// attribute phases, extremes included; random ops with bursts of text
		for (int ph = 0; ph < 5; ph++) begin
			write_attr(ph == 0 ? 8'h00 : ph == 1 ? 8'hFF : 8'($urandom));
			for (int i = 0; i < 10; i++) begin
				if ($urandom_range(0, 2) == 0) begin
					repeat ($urandom_range(3, 6))
						pending_cmds.push_back(mk(OP_PUTC, 8'($urandom_range(32, 255)),
							8'd0, 8'd0));
				end
				pending_cmds.push_back(rand_cmd());
			end
			wait_drained();
		end
		write_attr(RESET_ATTR);
		pending_cmds.push_back(mk(OP_PUTC, 8'h42, 8'd0, 8'd0));
		pending_cmds.push_back(mk(OP_READ, 8'h00, 8'd0, 8'd0));
		feeding_done = 1'b1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			{op, char_code, col, row, line_count, fill_attr,
				win_top, win_left, win_bottom, win_right} <= '0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_views.push_back(apply_cmd(console_cmd_t'({op, char_code, col, row,
					line_count, fill_attr, win_top, win_left, win_bottom, win_right})));
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0 && (in_valid || gap_left != 0)) begin
					in_valid <= 1'b0;
					if (!in_valid)
						gap_left <= gap_left - 1;
				end else if (pending_cmds.size() != 0) begin
					{op, char_code, col, row, line_count, fill_attr,
						win_top, win_left, win_bottom, win_right} <= pending_cmds.pop_front();
					in_valid <= 1'b1;
					gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 3);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			mismatches <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_views.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result col=%0d row=%0d off=%0d data=%h",
							cursor_col, cursor_row, cursor_offset, cell_data);
					mismatches <= mismatches + 1;
				end else begin
					console_view_t e;
					e = expected_views.pop_front();
					if (e != {cursor_col, cursor_row, cursor_offset, cell_data}) begin
						if (mismatches < 10)
							$display("expected col=%0d row=%0d off=%0d data=%h, got col=%0d row=%0d off=%0d data=%h",
								e.cur_col, e.cur_row, e.offset, e.data,
								cursor_col, cursor_row, cursor_offset, cell_data);
						mismatches <= mismatches + 1;
					end
				end
				stall_left <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 3);
				out_stall <= 1'b0;
			end else if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		cycles = 0;
		while (!(feeding_done && pending_cmds.size() == 0 && !in_valid &&
				expected_views.size() == 0) && cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("text_console_cell_engine: mismatch");
		end else begin
			repeat (20) @(posedge clk);
			if (mismatches == 0 && expected_views.size() == 0)
				$display("text_console_cell_engine: match");
			else
				$display("text_console_cell_engine: mismatch");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/tcce_pkg.sv
hdl/tcce_ram.sv
hdl/tcce_ctrl.sv
hdl/tcce_dp.sv
hdl/text_console_cell_engine.sv
tb/text_console_cell_engine_test.sv
